FILE: rtl/tpa_pkg.sv
// Package for the temporal period aggregator: payload types, register
// indexes, period codes and shared constants. No dependencies.
package tpa_pkg;

   localparam int CellsDefault = 1024;
   localparam int CountBitsDefault = 16;
   localparam int SumBits = 48;

   localparam logic [1:0] CsrAggregateMode = 2'd0;
   localparam logic [1:0] CsrPeriodStep = 2'd1;
   localparam logic [1:0] CsrMissingValue = 2'd2;
   localparam logic [1:0] CsrActiveCells = 2'd3;

   localparam logic [1:0] StepDay = 2'd0;
   localparam logic [1:0] StepMonth = 2'd1;

   typedef struct packed {
      logic               mode;
      logic [9:0]         cell_index;
      logic signed [31:0] sample_value;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
   } req_type;

   typedef struct packed {
      logic [9:0]         out_cell;
      logic signed [31:0] out_value;
      logic               was_empty;
      logic [13:0]        period_year;
      logic [3:0]         period_month;
      logic [4:0]         period_day;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [47:0] mag;
      logic [31:0] mult;
      logic        neg;
   } div_cmd_type;

endpackage

FILE: rtl/temporal_period_aggregator.sv
// Temporal period aggregator: per-cell period average or gap-filled sum of
// Q16.16 grid samples. A request for an inactive cell goes from read back to
// idle; any other is evaluated and written, then output if it emits, and a
// division waits on the shared divider, one quotient bit a cycle. After reset
// a clearing pass zeroes the cell memories before the first request is taken.
module temporal_period_aggregator #(
   parameter int CELLS = tpa_pkg::CellsDefault,
   parameter int COUNT_BITS = tpa_pkg::CountBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tpa_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tpa_pkg::rsp_type  rsp_payload,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import tpa_pkg::*;

   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW = $clog2(CELLS + 1);
   localparam logic [COUNT_BITS-1:0] CountMax = '1;
   localparam logic signed [SumBits-1:0] SumMaxV = {1'b0, {(SumBits-1){1'b1}}};
   localparam logic signed [SumBits-1:0] SumMinV = {1'b1, {(SumBits-1){1'b0}}};

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EVAL  = 7'b0001000,
      S_DIV   = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic              agg_mode_ff;
   logic [1:0]        step_ff;
   logic [31:0]       missing_ff;
   logic [10:0]       active_ff;

   logic signed [SumBits-1:0] sum_mem [CELLS];
   logic [COUNT_BITS-1:0]     cnt_mem [CELLS];
   logic signed [SumBits-1:0] rd_sum_ff;
   logic [COUNT_BITS-1:0]     rd_cnt_ff;

   logic [COUNT_BITS-1:0] max_ff, max_in, cmax_ff, cmax_in;
   logic [13:0] hy_ff, hy_in;
   logic [3:0]  hm_ff, hm_in;
   logic [4:0]  hd_ff, hd_in;
   logic        seen_ff, seen_in, closing_ff, closing_in;
   logic [AW:0] clr_ff;

   req_type req_ff;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    emit_ff, emit_in;
   logic [COUNT_BITS-1:0] emax_ff, emax_in;
   logic    acc_ff, acc_in;
   logic    wr_en;
   logic signed [SumBits-1:0] wr_sum;
   logic [COUNT_BITS-1:0]     wr_cnt;
   logic [AW-1:0]             wr_addr;

   logic [CW-1:0] act;
   logic          in_act, is_last, same;
   logic signed [SumBits:0] sum_ext;
   logic signed [SumBits-1:0] base_sum, new_sum;
   logic [COUNT_BITS-1:0] base_cnt, new_cnt;
   logic [SumBits-1:0] mag;
   logic [31:0] mult;
   div_cmd_type cmd;
   logic div_done;
   logic [31:0] div_result;
   logic [13:0] ry;
   logic [3:0]  rm;
   logic [4:0]  rd;
   logic [COUNT_BITS-1:0] cur_max;
   logic req_fire;

   always_comb begin
      if (active_ff == 11'd0) act = CW'(1);
      else if (32'(active_ff) > CELLS) act = CW'(CELLS);
      else act = CW'(active_ff);
   end

   assign req_fire = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign in_act = (CW'(req_ff.cell_index) < act) && (32'(req_ff.cell_index) < CELLS);
   assign is_last = (CW'(req_ff.cell_index) == act - CW'(1));

   always_comb begin
      same = (req_ff.year == hy_ff);
      if (step_ff == StepMonth || step_ff == StepDay) same = same && (req_ff.month == hm_ff);
      if (step_ff == StepDay) same = same && (req_ff.day == hd_ff);
   end

   tpa_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock(clock), .reset(reset), .cmd(cmd), .divisor(rd_cnt_ff),
      .done(div_done), .result(div_result)
   );

   always_comb begin
      state_in = state_ff;
      max_in = max_ff;
      cmax_in = cmax_ff;
      hy_in = hy_ff;
      hm_in = hm_ff;
      hd_in = hd_ff;
      seen_in = seen_ff;
      closing_in = closing_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      emit_in = emit_ff;
      emax_in = emax_ff;
      acc_in = acc_ff;
      cmd = '0;
      wr_en = 1'b0;
      wr_addr = req_ff.cell_index[AW-1:0];
      wr_sum = '0;
      wr_cnt = '0;
      base_sum = emit_ff ? '0 : rd_sum_ff;
      base_cnt = emit_ff ? '0 : rd_cnt_ff;
      sum_ext = {base_sum[SumBits-1], base_sum} +
                (SumBits+1)'(signed'(req_ff.sample_value));
      if (sum_ext > (SumBits+1)'(SumMaxV)) new_sum = SumMaxV;
      else if (sum_ext < (SumBits+1)'(SumMinV)) new_sum = SumMinV;
      else new_sum = sum_ext[SumBits-1:0];
      new_cnt = base_cnt + COUNT_BITS'(1);
      mag = rd_sum_ff[SumBits-1] ? SumBits'(0) - rd_sum_ff : rd_sum_ff;
      mult = agg_mode_ff ? 32'(emax_ff) : 32'd1;
      ry = hy_ff;
      rm = hm_ff;
      rd = hd_ff;
      cur_max = max_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            if (32'(clr_ff) == CELLS - 1) state_in = S_IDLE;
         end
         S_IDLE: if (req_fire) state_in = S_READ;
         S_READ: state_in = in_act ? S_EVAL : S_IDLE;
         S_EVAL: begin
            emit_in = 1'b0;
            acc_in = 1'b0;
            if (req_ff.mode) begin
               if (seen_ff) begin
                  emit_in = 1'b1;
                  if (closing_ff) begin
                     closing_in = 1'b0;
                     ry = req_ff.year; rm = req_ff.month; rd = req_ff.day;
                  end
                  emax_in = max_ff;
                  if (is_last) begin
                     max_in = '0;
                     seen_in = 1'b0;
                  end
               end
            end else begin
               if (req_ff.cell_index == 10'd0) begin
                  if (closing_ff) begin
                     closing_in = 1'b0;
                     ry = req_ff.year; rm = req_ff.month; rd = req_ff.day;
                  end
                  if (!seen_ff) begin
                     ry = req_ff.year; rm = req_ff.month; rd = req_ff.day;
                     seen_in = 1'b1;
                  end else if (!same && !closing_ff) begin
                     closing_in = 1'b1;
                     cmax_in = max_ff;
                     cur_max = '0;
                  end
               end
               if (closing_in) begin
                  emit_in = 1'b1;
                  emax_in = cmax_in;
               end
               acc_in = (req_ff.sample_value != missing_ff);
               max_in = cur_max;
            end
            hy_in = ry; hm_in = rm; hd_in = rd;
            rsp_in.out_cell = req_ff.cell_index;
            rsp_in.was_empty = (rd_cnt_ff == '0);
            rsp_in.out_value = missing_ff;
            rsp_in.period_year = ry;
            rsp_in.period_month = (step_ff == StepMonth || step_ff == StepDay) ? rm : 4'd0;
            rsp_in.period_day = (step_ff == StepDay) ? rd : 5'd0;
            rsp_in.last = is_last;
            if (emit_in && rd_cnt_ff != '0) begin
               if (agg_mode_ff && emax_in == '0) begin
                  rsp_in.out_value = '0;
                  state_in = S_WRITE;
               end else begin
                  state_in = S_DIV;
                  acc_in = 1'b0;
               end
            end else begin
               state_in = S_WRITE;
            end
         end
         S_DIV: begin
            if (!div_done && !acc_ff && !rsp_valid_ff) begin
               cmd.start = 1'b1;
               acc_in = 1'b1;
            end
            cmd.mag = mag;
            cmd.mult = mult;
            cmd.neg = rd_sum_ff[SumBits-1];
            if (div_done) begin
               rsp_in.out_value = div_result;
               acc_in = !req_ff.mode && (req_ff.sample_value != missing_ff);
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en = 1'b1;
            wr_sum = base_sum;
            wr_cnt = base_cnt;
            if (acc_ff && base_cnt != CountMax) begin
               wr_sum = new_sum;
               wr_cnt = new_cnt;
               if (new_cnt > max_ff) max_in = new_cnt;
            end
            if (!req_ff.mode && closing_ff && is_last) begin
               closing_in = 1'b0;
               hy_in = req_ff.year; hm_in = req_ff.month; hd_in = req_ff.day;
            end
            state_in = emit_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         agg_mode_ff <= 1'b0;
         step_ff <= 2'd0;
         missing_ff <= 32'h8000_0000;
         active_ff <= 11'd1024;
         max_ff <= '0;
         cmax_ff <= '0;
         hy_ff <= '0;
         hm_ff <= '0;
         hd_ff <= '0;
         seen_ff <= 1'b0;
         closing_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_ff <= 1'b0;
         acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_ff + (AW+1)'(1);
         if (csr_write) begin
            unique case (csr_index)
               CsrAggregateMode: agg_mode_ff <= csr_data[0];
               CsrPeriodStep:    step_ff <= csr_data[1:0];
               CsrMissingValue:  missing_ff <= csr_data;
               CsrActiveCells:   active_ff <= csr_data[10:0];
               default: ;
            endcase
         end
         max_ff <= max_in;
         cmax_ff <= cmax_in;
         hy_ff <= hy_in;
         hm_ff <= hm_in;
         hd_ff <= hd_in;
         seen_ff <= seen_in;
         closing_ff <= closing_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_ff <= emit_in;
         acc_ff <= acc_in;
      end
      emax_ff <= emax_in;
      rsp_ff <= rsp_in;
      if (req_fire) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sum_mem[wr_addr] <= wr_sum;
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_sum_ff <= sum_mem[req_ff.cell_index[AW-1:0]];
      rd_cnt_ff <= cnt_mem[req_ff.cell_index[AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) req_fire |-> state_ff == S_IDLE;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("request while busy");

   property p_rsp_from_out;
      @(posedge clock) disable iff (reset) $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT;
   endproperty
   a_rsp_from_out: assert property (p_rsp_from_out) else $error("stray response");

   property p_closing_seen;
      @(posedge clock) disable iff (reset) closing_ff && state_ff == S_IDLE |-> seen_ff;
   endproperty
   a_closing_seen: assert property (p_closing_seen) else $error("closing without record");

endmodule

FILE: rtl/tpa_divider.sv
// Shared iterative unit for the temporal period aggregator: unsigned restoring
// division of an 80-bit product by a count, one quotient bit per cycle,
// preceded by a shift-add multiply, 16 bits per cycle. Depends on tpa_pkg.
module tpa_divider #(
   parameter int COUNT_BITS = tpa_pkg::CountBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tpa_pkg::div_cmd_type    cmd,
   input  logic [COUNT_BITS-1:0]   divisor,
   output logic                    done,
   output logic [31:0]             result
);
   import tpa_pkg::*;

   localparam int PW = SumBits + 32;
   localparam int DW = COUNT_BITS + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [31:0]         mult_ff, mult_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [PW-1:0]       quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic [DW-1:0]       trial;
   logic [DW:0]         diff;
   logic [PW-1:0]       mag_ext;
   logic [31:0]         cap;

   always_comb begin
      mag_ext = {{(PW-SumBits){1'b0}}, cmd.mag};
      trial = {rem_ff[DW-2:0], quo_ff[PW-1]};
      diff = {1'b0, trial} - {2'b00, divisor};
      cap = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      state_in = state_ff;
      prod_in = prod_ff;
      mult_in = mult_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               prod_in = '0;
               mult_in = cmd.mult;
               quo_in = mag_ext;
               neg_in = cmd.neg;
               cnt_in = 7'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = prod_ff + ((quo_ff * PW'(mult_ff[15:0])) << (cnt_ff[0] ? 16 : 0));
            mult_in = {16'd0, mult_ff[31:16]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[0]) begin
               state_in = S_DIV;
               cnt_in = 7'd0;
               rem_in = '0;
               quo_in = prod_in + PW'(divisor >> 1);
            end
         end
         S_DIV: begin
            if (!diff[DW]) begin
               rem_in = diff[DW-1:0];
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(PW - 1)) state_in = S_FIN;
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      mult_ff <= mult_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // Half the divisor is added to the dividend, which rounds to nearest.
   always_comb begin
      done = (state_ff == S_FIN);
      if (quo_ff > PW'(cap)) result = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else result = neg_ff ? 32'd0 - quo_ff[31:0] : quo_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (!reset && done) assert ($past(state_ff) == S_DIV)
         else $error("divider finished without dividing");
   end

   property p_start_idle;
      @(posedge clock) disable iff (reset) cmd.start |-> state_ff == S_IDLE;
   endproperty
   a_start_idle: assert property (p_start_idle) else $error("start while busy");

   property p_done_once;
      @(posedge clock) disable iff (reset) done |=> !done;
   endproperty
   a_done_once: assert property (p_done_once) else $error("done held");

endmodule
